// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; they become empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked at every clock edge outside reset
`define ASSERT_CLKD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLKD(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== rtl/xewd_pkg.sv =====
// ----------------------------------------------------------------------------
// xewd_pkg
// Item types, decode command record and entity name tables.
// ----------------------------------------------------------------------------
`default_nettype none

package xewd_pkg;

  localparam int unsigned NUM_ENT  = 6;
  localparam int unsigned NAME_LEN = 5;
  localparam int unsigned NUM_HELD = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } out_item_t;

  // one decoded item: optional '&' plus held letters, then an optional tail byte
  typedef struct packed {
    logic                     flush;
    logic [2:0]               flush_n;
    logic [NUM_HELD-1:0][7:0] letters;
    logic                     tail_en;
    logic [7:0]               tail;
    logic                     last;
  } cmd_t;

  localparam logic [7:0] ENT_NAME [NUM_ENT][NAME_LEN] = '{
    '{"a", "m", "p", ";", 8'h00},
    '{"l", "t", ";", 8'h00, 8'h00},
    '{"g", "t", ";", 8'h00, 8'h00},
    '{"q", "u", "o", "t", ";"},
    '{"a", "p", "o", "s", ";"},
    '{"n", "b", "s", "p", ";"}
  };

  localparam logic [7:0] ENT_CHAR [NUM_ENT] = '{"&", "<", ">", "\"", "'", " "};

  localparam logic [7:0] CH_AMP  = "&";
  localparam logic [7:0] CH_HASH = "#";
  localparam logic [7:0] CH_SEMI = ";";
  localparam logic [7:0] CH_SP   = " ";
  localparam logic [7:0] CH_NUL  = 8'h00;

endpackage

`default_nettype wire

// ===== rtl/xml_entity_whitespace_decoder_core.sv =====
// ----------------------------------------------------------------------------
// xml_entity_whitespace_decoder_core
// XML text span decoder: entity expansion and whitespace folding.
// ----------------------------------------------------------------------------
// Takes one raw byte per cycle while full is low and returns decoded bytes
// through a queue-style result port; the first result of a byte is written
// to the command queue and then to the output register before it reaches
// the result ports. The decode front classifies each byte as it is taken,
// and the result stage delivers one item per cycle while results are
// popped, so a byte yielding one result sustains one byte per cycle. A
// failed entity match replays '&' and up to four held letters plus the
// current byte: up to six results, absorbed by a QUEUE_DEPTH-entry command
// queue before full rises. The final byte of a span always yields at least
// one item; if it carries no byte, out_valid is low on it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module xml_entity_whitespace_decoder_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  output logic                full,
  input  xewd_pkg::in_item_t  in_data,
  output logic                empty,
  input  wire                 pop,
  output xewd_pkg::out_item_t out_data
);
  import xewd_pkg::*;

  logic take;
  logic q_push, q_pop, q_full, q_empty;
  cmd_t q_in, q_head;

  assign full = q_full;
  assign take = push && !q_full;

  xewd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .in_data  (in_data),
    .cmd_push (q_push),
    .cmd_data (q_in)
  );

  xewd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  xewd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_empty (q_empty),
    .head_pop   (q_pop),
    .pop        (pop),
    .empty      (empty),
    .out_data   (out_data)
  );

  `ASSERT_CLKD(a_no_q_overflow, q_push |-> !q_full, "command queue overflow")
  `ASSERT_CLKD(a_no_q_underflow, q_pop |-> !q_empty, "command queue underflow")
  `ASSERT_CLKD(a_pop_loads_out, q_pop |=> !empty, "retired command left no item")

endmodule

`default_nettype wire

// ===== rtl/xewd_queue.sv =====
// ----------------------------------------------------------------------------
// xewd_queue
// Short command queue between the decode front and the output back.
// ----------------------------------------------------------------------------
`default_nettype none

module xewd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  xewd_pkg::cmd_t   push_data,
  output logic             full,
  input  wire              pop,
  output xewd_pkg::cmd_t   head,
  output logic             empty
);
  import xewd_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r,  count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/xewd_front.sv =====
// ----------------------------------------------------------------------------
// xewd_front
// Decode state machine: classifies each accepted byte into a command.
// ----------------------------------------------------------------------------
`default_nettype none

module xewd_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 take,
  input  xewd_pkg::in_item_t  in_data,
  output logic                cmd_push,
  output xewd_pkg::cmd_t      cmd_data
);
  import xewd_pkg::*;

  typedef enum logic [5:0] {
    M_PLAIN = 6'b000001,
    M_AMP   = 6'b000010,
    M_HASH  = 6'b000100,
    M_DIGIT = 6'b001000,
    M_SKIP  = 6'b010000,
    M_STOP  = 6'b100000
  } mode_t;

  mode_t                mode_r, mode_nxt;
  logic [7:0]           held_r [NUM_HELD];
  logic [2:0]           held_cnt_r, held_cnt_nxt;
  logic [NUM_ENT-1:0]   cand_r, cand_nxt;
  logic [7:0]           code_r, code_nxt;
  logic                 emitted_r, emitted_nxt;
  logic                 space_r, space_nxt;

  logic [7:0]           c, lc;
  logic                 is_ws, is_dig, held_we, do_plain;
  logic [NUM_ENT-1:0]   match_vec;
  logic [7:0]           hit_char;
  logic [7:0]           held_v [NUM_HELD];

  assign c      = in_data.in_byte;
  assign lc     = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  assign is_ws  = (c >= 8'd9 && c <= 8'd13) || (c == CH_SP);
  assign is_dig = (c >= "0" && c <= "9");

  // candidate entities still consistent with the held prefix
  always_comb begin
    hit_char = CH_NUL;
    for (int k = 0; k < NUM_ENT; k++) begin
      match_vec[k] = cand_r[k] && (lc == ENT_NAME[k][held_cnt_r]);
    end
    for (int k = NUM_ENT - 1; k >= 0; k--) begin
      if (match_vec[k]) begin
        hit_char = ENT_CHAR[k];
      end
    end
  end

  always_comb begin
    mode_nxt     = mode_r;
    held_cnt_nxt = held_cnt_r;
    cand_nxt     = cand_r;
    code_nxt     = code_r;
    emitted_nxt  = emitted_r;
    space_nxt    = space_r;
    held_we      = 1'b0;
    do_plain     = 1'b0;
    cmd_data     = '0;
    cmd_data.last = in_data.is_last;

    unique case (mode_r)
      M_PLAIN: do_plain = 1'b1;
      M_AMP: begin
        if (held_cnt_r == '0 && c == CH_NUL) begin
          mode_nxt = M_STOP;
        end else if (held_cnt_r == '0 && c == CH_HASH) begin
          mode_nxt = M_HASH;
        end else if (|match_vec) begin
          if (c == CH_SEMI) begin
            cmd_data.tail_en = 1'b1;
            cmd_data.tail    = hit_char;
            emitted_nxt      = 1'b1;
            held_cnt_nxt     = '0;
            mode_nxt         = M_PLAIN;
          end else if (held_cnt_r < 3'(NUM_HELD)) begin
            held_we      = 1'b1;
            held_cnt_nxt = held_cnt_r + 1'b1;
            cand_nxt     = match_vec;
          end
        end else begin
          // no entity fits: replay '&' and the letters, then treat the byte as text
          cmd_data.flush   = 1'b1;
          cmd_data.flush_n = held_cnt_r;
          emitted_nxt      = 1'b1;
          held_cnt_nxt     = '0;
          mode_nxt         = M_PLAIN;
          do_plain         = 1'b1;
        end
      end
      M_HASH: begin
        if (is_dig) begin
          code_nxt = c - "0";
          mode_nxt = M_DIGIT;
        end else begin
          mode_nxt = M_STOP;
        end
      end
      M_DIGIT: begin
        if (is_dig) begin
          code_nxt = {code_r[4:0], 3'b000} + {code_r[6:0], 1'b0} + (c - "0");
        end else begin
          cmd_data.tail_en = 1'b1;
          cmd_data.tail    = code_r;
          emitted_nxt      = 1'b1;
          if (c == CH_SEMI) begin
            mode_nxt = M_PLAIN;
          end else if (c == CH_NUL) begin
            mode_nxt = M_STOP;
          end else begin
            mode_nxt = M_SKIP;
          end
        end
      end
      M_SKIP: begin
        if (c == CH_SEMI) begin
          mode_nxt = M_PLAIN;
        end else if (c == CH_NUL) begin
          mode_nxt = M_STOP;
        end
      end
      M_STOP: mode_nxt = M_STOP;
      default: mode_nxt = M_STOP;
    endcase

    if (do_plain) begin
      priority if (c == CH_NUL) begin
        mode_nxt = M_STOP;
      end else if (is_ws) begin
        if (!space_r) begin
          if (emitted_nxt) begin
            cmd_data.tail_en = 1'b1;
            cmd_data.tail    = CH_SP;
          end
          space_nxt = 1'b1;
        end
      end else if (c == CH_AMP) begin
        space_nxt    = 1'b0;
        held_cnt_nxt = '0;
        cand_nxt     = '1;
        mode_nxt     = M_AMP;
      end else begin
        space_nxt        = 1'b0;
        cmd_data.tail_en = 1'b1;
        cmd_data.tail    = c;
        emitted_nxt      = 1'b1;
      end
    end

    for (int i = 0; i < NUM_HELD; i++) begin
      held_v[i] = (held_we && held_cnt_r[1:0] == 2'(i)) ? c : held_r[i];
      cmd_data.letters[i] = held_v[i];
    end

    if (in_data.is_last) begin
      // span closes inside a name or a number
      if (mode_nxt == M_AMP && held_cnt_nxt != '0) begin
        cmd_data.flush   = 1'b1;
        cmd_data.flush_n = held_cnt_nxt;
      end else if (mode_nxt == M_DIGIT) begin
        cmd_data.tail_en = 1'b1;
        cmd_data.tail    = code_nxt;
      end
      mode_nxt     = M_PLAIN;
      held_cnt_nxt = '0;
      code_nxt     = '0;
      emitted_nxt  = 1'b0;
      space_nxt    = 1'b0;
    end

    cmd_push = take && (cmd_data.flush || cmd_data.tail_en || cmd_data.last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= M_PLAIN;
      held_cnt_r <= '0;
      cand_r     <= '1;
      code_r     <= '0;
      emitted_r  <= 1'b0;
      space_r    <= 1'b0;
    end else if (take) begin
      mode_r     <= mode_nxt;
      held_cnt_r <= held_cnt_nxt;
      cand_r     <= cand_nxt;
      code_r     <= code_nxt;
      emitted_r  <= emitted_nxt;
      space_r    <= space_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && held_we) begin
      held_r[held_cnt_r[1:0]] <= c;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/xewd_back.sv =====
// ----------------------------------------------------------------------------
// xewd_back
// Expands queued commands into result items in an output register, one
// per cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
`default_nettype none

module xewd_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  xewd_pkg::cmd_t      head,
  input  wire                 head_empty,
  output logic                head_pop,
  input  wire                 pop,
  output logic                empty,
  output xewd_pkg::out_item_t out_data
);
  import xewd_pkg::*;

  logic [2:0] idx_r, idx_nxt;
  logic [2:0] total, eff, letter_idx;
  logic       final_el, step;
  out_item_t  el;
  out_item_t  out_r;
  logic       out_full_r;

  assign total    = (head.flush ? head.flush_n + 3'd1 : 3'd0) + {2'b00, head.tail_en};
  assign eff      = (total == '0) ? 3'd1 : total;
  assign final_el = (idx_r == eff - 3'd1);
  assign step     = !head_empty && (!out_full_r || pop);
  assign head_pop = step && final_el;
  assign idx_nxt  = step ? (final_el ? 3'd0 : idx_r + 3'd1) : idx_r;
  assign letter_idx = idx_r - 3'd1;

  always_comb begin
    el = '0;
    priority if (head.flush && idx_r == '0) begin
      el.out_byte  = CH_AMP;
      el.out_valid = 1'b1;
    end else if (head.flush && idx_r <= head.flush_n) begin
      el.out_byte  = head.letters[letter_idx[1:0]];
      el.out_valid = 1'b1;
    end else if (head.tail_en) begin
      el.out_byte  = head.tail;
      el.out_valid = 1'b1;
    end else begin
      // empty closing item
      el.out_byte  = CH_NUL;
      el.out_valid = 1'b0;
    end
    el.out_last = head.last && final_el;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      out_full_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (step) begin
        out_full_r <= 1'b1;
      end else if (pop) begin
        out_full_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= el;
    end
  end

  assign empty    = !out_full_r;
  assign out_data = out_r;

endmodule

`default_nettype wire
